@@ design/qte_pkg.sv @@
// Shared constants, types and angle table for the quaternion to Euler converter.
`timescale 1ns / 1ps
`default_nettype none

package qte_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int CORDIC_STEPS    = 16;

    // Q.30 products, CORDIC lane data, Q.24 angles and square root widths.
    localparam int QW         = 33;
    localparam int DW         = 36;
    localparam int AW         = 28;
    localparam int SQ_W       = 62;
    localparam int ROOT_W     = 31;
    localparam int SQRT_CELLS = 31;
    localparam int SQ_IDX_W   = 5;
    localparam int STEP_W     = $clog2(CORDIC_STEPS);
    localparam int OUT_W      = 16;

    localparam logic signed [AW-1:0]    ANG_PI_HALF       = AW'(26353589);
    localparam logic signed [AW+1:0]    ANG_TWO_PI        = (AW+2)'(105414357);
    localparam logic signed [OUT_W-1:0] OUT_PI_HALF       = OUT_W'(6434);
    localparam logic signed [OUT_W-1:0] OUT_THREE_PI_HALF = OUT_W'(19302);

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } pole_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [DW-1:0] a0y;
        logic signed [DW-1:0] a0x;
        logic signed [DW-1:0] a1y;
        logic signed [DW-1:0] a1x;
        logic signed [DW-1:0] s;
        pole_t                pole;
    } side_t;

    // atan(2^-i) in Q.24; beyond the table the angle is 2^(24-i).
    function automatic logic signed [AW-1:0] step_angle(input int i);
        logic signed [AW-1:0] ang;
        unique case (i)
            0:       ang = AW'(13176795);
            1:       ang = AW'(7778716);
            2:       ang = AW'(4110060);
            3:       ang = AW'(2086331);
            4:       ang = AW'(1047214);
            5:       ang = AW'(524117);
            6:       ang = AW'(262123);
            7:       ang = AW'(131069);
            default: ang = (i <= 24) ? (AW'(1) <<< (24 - i)) : '0;
        endcase
        return ang;
    endfunction

endpackage

`default_nettype wire

@@ design/qte_cordic_cell.sv @@
// One vectoring CORDIC iteration with its output register.
`timescale 1ns / 1ps
`default_nettype none

module qte_cordic_cell (
    input  wire logic                       clk,
    input  wire logic [qte_pkg::STEP_W-1:0] step,
    input  wire qte_pkg::cordic_t           din,
    output qte_pkg::cordic_t                dout
);
    import qte_pkg::*;

    logic signed [DW-1:0] x_in;
    logic signed [DW-1:0] y_in;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [AW-1:0] ang;
    cordic_t              cell_next;
    cordic_t              cell_reg;

    always_comb
    begin
        x_in      = din.x;
        y_in      = din.y;
        dx        = x_in >>> step;
        dy        = y_in >>> step;
        ang       = step_angle(int'(step));
        cell_next = din;
        priority if (y_in > 0)
        begin
            cell_next.x = x_in + dy;
            cell_next.y = y_in - dx;
            cell_next.z = din.z + ang;
        end
        else if (y_in < 0)
        begin
            cell_next.x = x_in - dy;
            cell_next.y = y_in + dx;
            cell_next.z = din.z - ang;
        end
        else
        begin
            // A vector already on the axis passes through unchanged.
            cell_next = din;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

@@ design/qte_sqrt_cell.sv @@
// One digit of the restoring integer square root with its output register.
`timescale 1ns / 1ps
`default_nettype none

module qte_sqrt_cell (
    input  wire logic                         clk,
    input  wire logic [qte_pkg::SQ_IDX_W-1:0] k,
    input  wire qte_pkg::sqrt_t               din,
    output qte_pkg::sqrt_t                    dout
);
    import qte_pkg::*;

    logic [SQ_W-1:0] bit_val;
    logic [SQ_W-1:0] trial;
    sqrt_t           cell_next;
    sqrt_t           cell_reg;

    always_comb
    begin
        bit_val = SQ_W'(1) << {k, 1'b0};
        trial   = din.root + bit_val;
        if (din.rem >= trial)
        begin
            cell_next.rem  = din.rem - trial;
            cell_next.root = (din.root >> 1) + bit_val;
        end
        else
        begin
            cell_next.rem  = din.rem;
            cell_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

@@ design/quaternion_to_euler_top.sv @@
// Top level of the quaternion to Euler angle converter.
//
// A transaction is accepted at each rising edge with start high; busy is
// always low, so a new quaternion may enter in every cycle. Components are
// signed Q1.15, angles come out in signed Q3.12 radians with a pole code.
// Each result is shown for exactly one cycle with done high, in the order of
// acceptance. Throughput is one result per cycle. The pipeline holds four
// front stages (capture, products, sums and pole test, squaring), one cell per
// root bit of the 31-cell square root chain, one pre-rotation stage, one cell
// per iteration in each of three 16-cell CORDIC chains, and the output
// register. The receiver cannot stall, so results are never held. Reset
// empties the pipeline (no done until new transactions arrive) and sets
// pole_threshold to 16383. Write pole_threshold through cfg_we/cfg_wdata
// only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_euler_top (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        start,
    output logic                                             busy,
    input  wire logic                                        cfg_we,
    input  wire logic [14:0]                                 cfg_wdata,
    input  wire logic signed [qte_pkg::COMPONENT_WIDTH-1:0]  quat_x,
    input  wire logic signed [qte_pkg::COMPONENT_WIDTH-1:0]  quat_y,
    input  wire logic signed [qte_pkg::COMPONENT_WIDTH-1:0]  quat_z,
    input  wire logic signed [qte_pkg::COMPONENT_WIDTH-1:0]  quat_w,
    output logic                                             done,
    output logic signed [qte_pkg::OUT_W-1:0]                 rot_x,
    output logic signed [qte_pkg::OUT_W-1:0]                 rot_y,
    output logic signed [qte_pkg::OUT_W-1:0]                 rot_z,
    output logic [1:0]                                       pole
);
    import qte_pkg::*;

    localparam int CW    = COMPONENT_WIDTH;
    localparam int FRAC  = CW - 1;
    localparam int PFRAC = 2 * FRAC;
    localparam int PSHR  = (PFRAC >= 30) ? PFRAC - 30 : 0;
    localparam int PSHL  = (PFRAC < 30) ? 30 - PFRAC : 0;
    localparam int CSHR  = (FRAC >= 30) ? FRAC - 30 : 0;
    localparam int CSHL  = (FRAC < 30) ? 30 - FRAC : 0;
    localparam int LAT   = 4 + SQRT_CELLS + 1 + CORDIC_STEPS + 1;

    localparam logic signed [DW-1:0] ONE_Q30 = DW'(1073741824);

    function automatic logic signed [QW-1:0] rescale_prod(
        input logic signed [2*CW-1:0] p
    );
        logic signed [63:0] wide;
        wide = 64'(p);
        return QW'((wide >>> PSHR) <<< PSHL);
    endfunction

    function automatic logic signed [DW-1:0] rescale_comp(
        input logic signed [CW-1:0] v
    );
        logic signed [63:0] wide;
        wide = 64'(v);
        return DW'((wide >>> CSHR) <<< CSHL);
    endfunction

    // Moves a left half-plane vector into the right half plane.
    function automatic cordic_t prerotate(
        input logic signed [DW-1:0] y,
        input logic signed [DW-1:0] x
    );
        cordic_t r;
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                r.x = y;
                r.y = -x;
                r.z = ANG_PI_HALF;
            end
            else
            begin
                r.x = -y;
                r.y = x;
                r.z = -ANG_PI_HALF;
            end
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [AW+1:0] a);
        logic signed [AW+1:0] rounded;
        rounded = (a + (AW+2)'(2048)) >>> 12;
        return rounded[OUT_W-1:0];
    endfunction

    // Configuration and valid line.
    logic [14:0]     pole_threshold_reg;
    logic [LAT-1:0]  vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_threshold_reg <= 15'd16383;
            vld_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                pole_threshold_reg <= cfg_wdata;
            end
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    // Stage 1: capture.
    logic signed [CW-1:0] x_reg, y_reg, z_reg, w_reg;

    always_ff @(posedge clk)
    begin
        x_reg <= quat_x;
        y_reg <= quat_y;
        z_reg <= quat_z;
        w_reg <= quat_w;
    end

    // Stage 2: products in Q.30.
    logic signed [QW-1:0] pxy_reg, pzw_reg, pxw_reg, pyz_reg, pxx_reg;
    logic signed [QW-1:0] pzz_reg, pyw_reg, pxz_reg, pyy_reg;
    logic signed [DW-1:0] xq_reg, wq_reg;

    always_ff @(posedge clk)
    begin
        pxy_reg <= rescale_prod(x_reg * y_reg);
        pzw_reg <= rescale_prod(z_reg * w_reg);
        pxw_reg <= rescale_prod(x_reg * w_reg);
        pyz_reg <= rescale_prod(y_reg * z_reg);
        pxx_reg <= rescale_prod(x_reg * x_reg);
        pzz_reg <= rescale_prod(z_reg * z_reg);
        pyw_reg <= rescale_prod(y_reg * w_reg);
        pxz_reg <= rescale_prod(x_reg * z_reg);
        pyy_reg <= rescale_prod(y_reg * y_reg);
        xq_reg  <= rescale_comp(x_reg);
        wq_reg  <= rescale_comp(w_reg);
    end

    // Stage 3: pole test, numerators, denominators and the asin argument.
    logic signed [QW:0]   test;
    logic signed [QW:0]   t15;
    logic signed [QW:0]   thr_s;
    logic signed [DW-1:0] s_dbl;
    side_t                side3_next;
    side_t                side3_reg;

    always_comb
    begin
        test  = (QW+1)'(pxy_reg) + (QW+1)'(pzw_reg);
        t15   = test >>> 15;
        thr_s = (QW+1)'({1'b0, pole_threshold_reg});
        s_dbl = DW'(test) <<< 1;

        side3_next.a0y = (DW'(pxw_reg) - DW'(pyz_reg)) <<< 1;
        side3_next.a0x = ONE_Q30 - ((DW'(pxx_reg) + DW'(pzz_reg)) <<< 1);
        side3_next.a1y = (DW'(pyw_reg) - DW'(pxz_reg)) <<< 1;
        side3_next.a1x = ONE_Q30 - ((DW'(pyy_reg) + DW'(pzz_reg)) <<< 1);

        priority if (s_dbl > ONE_Q30)
        begin
            side3_next.s = ONE_Q30;
        end
        else if (s_dbl < -ONE_Q30)
        begin
            side3_next.s = -ONE_Q30;
        end
        else
        begin
            side3_next.s = s_dbl;
        end

        priority if (t15 > thr_s)
        begin
            side3_next.pole = POLE_NORTH;
        end
        else if (t15 < -thr_s)
        begin
            side3_next.pole = POLE_SOUTH;
        end
        else
        begin
            side3_next.pole = POLE_NONE;
        end

        // At either pole the second lane works on atan2(x, w).
        if (side3_next.pole != POLE_NONE)
        begin
            side3_next.a1y = xq_reg;
            side3_next.a1x = wq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side3_next;
    end

    // Stage 4: square of the asin argument.
    logic signed [DW-1:0] s3;
    logic [ROOT_W-1:0]    s_abs;
    logic [SQ_W-1:0]      sq_reg;
    side_t                side4_reg;

    always_comb
    begin
        s3    = side3_reg.s;
        s_abs = (s3 < 0) ? ROOT_W'(-s3) : ROOT_W'(s3);
    end

    always_ff @(posedge clk)
    begin
        sq_reg    <= s_abs * s_abs;
        side4_reg <= side3_reg;
    end

    // Square root chain for the cosine of the asin angle.
    sqrt_t sq_bus [SQRT_CELLS+1];
    side_t side_dly_reg [SQRT_CELLS];

    assign sq_bus[0].rem  = (SQ_W'(1) << 60) - sq_reg;
    assign sq_bus[0].root = '0;

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        qte_sqrt_cell u_cell (
            .clk  (clk),
            .k    (SQ_IDX_W'(SQRT_CELLS - 1 - i)),
            .din  (sq_bus[i]),
            .dout (sq_bus[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side4_reg;
        for (int i = 1; i < SQRT_CELLS; i++)
        begin
            side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // Pre-rotation into the right half plane for all three lanes.
    side_t                side_end;
    logic signed [DW-1:0] cos_val;
    cordic_t              pre_next [3];
    cordic_t              pre_reg  [3];
    pole_t                pole_pre_reg;

    always_comb
    begin
        side_end    = side_dly_reg[SQRT_CELLS-1];
        cos_val     = DW'(sq_bus[SQRT_CELLS].root[ROOT_W-1:0]);
        pre_next[0] = prerotate(side_end.a0y, side_end.a0x);
        pre_next[1] = prerotate(side_end.a1y, side_end.a1x);
        pre_next[2] = prerotate(side_end.s, cos_val);
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            pre_reg[l] <= pre_next[l];
        end
        pole_pre_reg <= side_end.pole;
    end

    // Three CORDIC chains side by side.
    cordic_t cd_bus [3][CORDIC_STEPS+1];
    pole_t   pole_dly_reg [CORDIC_STEPS];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign cd_bus[l][0] = pre_reg[l];
        for (genvar k = 0; k < CORDIC_STEPS; k++)
        begin : g_step
            qte_cordic_cell u_cell (
                .clk  (clk),
                .step (STEP_W'(k)),
                .din  (cd_bus[l][k]),
                .dout (cd_bus[l][k+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        pole_dly_reg[0] <= pole_pre_reg;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            pole_dly_reg[i] <= pole_dly_reg[i-1];
        end
    end

    // Output stage.
    pole_t                pole_end;
    logic signed [AW+1:0] a1;
    logic signed [AW+1:0] a1_neg;
    logic signed [OUT_W-1:0] rot_x_next, rot_y_next, rot_z_next;
    logic signed [OUT_W-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    pole_t                pole_reg;

    always_comb
    begin
        pole_end = pole_dly_reg[CORDIC_STEPS-1];
        a1       = (AW+2)'(cd_bus[1][CORDIC_STEPS].z) <<< 1;
        a1_neg   = -a1;
        if (a1_neg < 0)
        begin
            a1_neg = a1_neg + ANG_TWO_PI;
        end
        else if (a1_neg >= ANG_TWO_PI)
        begin
            a1_neg = a1_neg - ANG_TWO_PI;
        end

        unique case (pole_end)
            POLE_NORTH:
            begin
                rot_x_next = '0;
                rot_y_next = to_out(a1);
                rot_z_next = OUT_PI_HALF;
            end
            POLE_SOUTH:
            begin
                rot_x_next = '0;
                rot_y_next = to_out(a1_neg);
                rot_z_next = OUT_THREE_PI_HALF;
            end
            default:
            begin
                rot_x_next = to_out((AW+2)'(cd_bus[0][CORDIC_STEPS].z));
                rot_y_next = to_out((AW+2)'(cd_bus[1][CORDIC_STEPS].z));
                rot_z_next = to_out((AW+2)'(cd_bus[2][CORDIC_STEPS].z));
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rot_x_reg <= rot_x_next;
        rot_y_reg <= rot_y_next;
        rot_z_reg <= rot_z_next;
        pole_reg  <= pole_end;
    end

    assign rot_x = rot_x_reg;
    assign rot_y = rot_y_reg;
    assign rot_z = rot_z_reg;
    assign pole  = pole_reg;

    // Every accepted transaction leaves the pipeline after a fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transaction did not complete on time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    a_north: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pole == POLE_NORTH) |-> (rot_x == '0 && rot_z == OUT_PI_HALF))
        else $error("north pole result has wrong fixed angles");

    a_south: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pole == POLE_SOUTH)
            |-> (rot_x == '0 && !rot_y[OUT_W-1] && rot_z == OUT_THREE_PI_HALF))
        else $error("south pole result out of range");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the quaternion to Euler angle converter.
`timescale 1ns / 1ps

class euler_scoreboard;
    typedef struct {
        logic [15:0]    rx;
        logic [15:0]    ry;
        logic [15:0]    rz;
        qte_pkg::pole_t pole;
    } angles_t;

    angles_t     pending_angles[$];
    logic [14:0] threshold;
    int          mismatches;

    function new();
        threshold  = 15'd16383;
        mismatches = 0;
    endfunction

    static function longint shr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint cordic_angle(int i);
        longint head[8] = '{13176795, 7778716, 4110060, 2086331,
                            1047214, 524117, 262123, 131069};
        if (i < 8)
            return head[i];
        return longint'(1) << (24 - i);
    endfunction

    // Vectoring-mode CORDIC, angle in Q.24.
    static function longint vector_angle(longint y, longint x);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; acc = 26353589;
            end
            else
            begin
                t = x; x = -y; y = t; acc = -26353589;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = shr(x, i);
            dy = shr(y, i);
            if (y > 0)
            begin
                x = x + dy; y = y - dx; acc = acc + cordic_angle(i);
            end
            else if (y < 0)
            begin
                x = x - dy; y = y + dx; acc = acc - cordic_angle(i);
            end
        end
        return acc;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    static function logic [15:0] round_q12(longint a);
        longint v;
        v = shr(a + 2048, 12);
        return v[15:0];
    endfunction

    function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic signed [15:0] qw);
        longint  x;
        longint  y;
        longint  z;
        longint  w;
        longint  test;
        longint  t15;
        longint  thr;
        longint  a;
        longint  s;
        longint  one;
        longint  c;
        angles_t e;
        x    = qx;
        y    = qy;
        z    = qz;
        w    = qw;
        one  = longint'(1) << 30;
        test = x * y + z * w;
        t15  = shr(test, 15);
        thr  = threshold;
        if (t15 > thr)
        begin
            a      = 2 * vector_angle(x << 15, w << 15);
            e.rx   = 16'd0;
            e.ry   = round_q12(a);
            e.rz   = qte_pkg::OUT_PI_HALF;
            e.pole = qte_pkg::POLE_NORTH;
        end
        else if (t15 < -thr)
        begin
            a = -2 * vector_angle(x << 15, w << 15);
            if (a < 0)
                a = a + 105414357;
            if (a >= 105414357)
                a = a - 105414357;
            e.rx   = 16'd0;
            e.ry   = round_q12(a);
            e.rz   = qte_pkg::OUT_THREE_PI_HALF;
            e.pole = qte_pkg::POLE_SOUTH;
        end
        else
        begin
            s = 2 * test;
            if (s > one)
                s = one;
            if (s < -one)
                s = -one;
            c      = longint'(int_sqrt(longint'(one * one - s * s)));
            e.rx   = round_q12(vector_angle(2 * (x * w - y * z), one - 2 * (x * x + z * z)));
            e.ry   = round_q12(vector_angle(2 * (y * w - x * z), one - 2 * (y * y + z * z)));
            e.rz   = round_q12(vector_angle(s, c));
            e.pole = qte_pkg::POLE_NONE;
        end
        pending_angles.push_back(e);
    endfunction

    function void check_angles(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                               logic [1:0] pl);
        angles_t e;
        if (pending_angles.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %0d %0d %0d pole %0d", $signed(rx),
                         $signed(ry), $signed(rz), pl);
            return;
        end
        e = pending_angles.pop_front();
        if (rx !== e.rx || ry !== e.ry || rz !== e.rz || pl !== e.pole)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %0d %0d %0d pole %0d, got %0d %0d %0d pole %0d",
                         $signed(e.rx), $signed(e.ry), $signed(e.rz), e.pole,
                         $signed(rx), $signed(ry), $signed(rz), pl);
        end
    endfunction
endclass

module testbench;
    localparam int STALL_LIMIT = 1000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cfg_we;
    logic [14:0]        cfg_wdata;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               done;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic [1:0]         pole;

    euler_scoreboard sb = new();
    int              idle_pct;
    int              quiet_cycles;

    quaternion_to_euler_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .pole(pole)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_quat(quat_x, quat_y, quat_z, quat_w);
                quiet_cycles = 0;
            end
            else
                quiet_cycles++;
            if (done)
                sb.check_angles(rot_x, rot_y, rot_z, pole);
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task send_quat(input logic [15:0] x, input logic [15:0] y,
                   input logic [15:0] z, input logic [15:0] w);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        quat_w <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_angles.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task write_threshold(input logic [14:0] v);
        drain_pipe();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sb.threshold = v;
    endtask

    task send_random_quat();
        real     c[4];
        real     n;
        int      k;
        logic [15:0] v[4];
        int      a;
        k = $urandom_range(9);
        if (k < 5)
        begin
            // Unit quaternion with random direction.
            n = 0.0;
            for (int i = 0; i < 4; i++)
            begin
                c[i] = ($urandom_range(65535) - 32768.0) / 32768.0;
                n    = n + c[i] * c[i];
            end
            if (n < 1.0e-6)
                n = 1.0;
            n = $sqrt(n);
            for (int i = 0; i < 4; i++)
                v[i] = 16'($rtoi(c[i] / n * 32767.0));
        end
        else if (k < 8)
        begin
            // Close to a pole: x*y + z*w near one half of either sign.
            a    = 16384 + $urandom_range(600) - 300;
            v[0] = 16'(a + $urandom_range(200) - 100);
            v[1] = 16'(a + $urandom_range(200) - 100);
            v[2] = 16'(a + $urandom_range(200) - 100);
            v[3] = 16'(a + $urandom_range(200) - 100);
            if ($urandom_range(1))
            begin
                v[1] = -v[1];
                v[3] = -v[3];
            end
            if ($urandom_range(1))
            begin
                v[0] = -v[0];
                v[1] = -v[1];
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                v[i] = 16'($urandom);
        end
        send_quat(v[0], v[1], v[2], v[3]);
    endtask

    initial
    begin
        logic [14:0] thr_list[6];
        rst_n        = 1'b0;
        start        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        quat_x       = '0;
        quat_y       = '0;
        quat_z       = '0;
        quat_w       = '0;
        quiet_cycles = 0;
        idle_pct     = 26;
        thr_list     = '{15'd16383, 15'd0, 15'd16384, 15'd32767,
                         15'($urandom), 15'($urandom_range(16384))};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, identity, both poles, non-unit inputs.
        send_quat(16'd0, 16'd0, 16'd0, 16'd0);
        send_quat(16'd0, 16'd0, 16'd0, 16'sd32767);
        send_quat(16'd0, 16'd0, 16'd0, -16'sd32768);
        send_quat(16'sd32767, 16'd0, 16'd0, 16'd0);
        send_quat(16'd0, 16'sd32767, 16'd0, 16'd0);
        send_quat(16'd0, 16'd0, 16'sd32767, 16'd0);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
        send_quat(-16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384);
        send_quat(16'sd16384, 16'sd16383, 16'sd16384, 16'sd16383);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_quat(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quat(16'd0, 16'sd16384, 16'sd16384, 16'd0);
        send_quat(16'd0, 16'sd23170, 16'sd23170, 16'd0);

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = (ph < 2) ? 26 : ((ph < 4) ? 77 : 0);
            write_threshold(thr_list[ph]);
            if (ph == 3)
            begin
                // Above one half in the register: the asin argument can saturate.
                send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
                send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
                send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
            end
            for (int i = 0; i < 175; i++)
                send_random_quat();
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_angles.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
design/qte_pkg.sv
design/qte_cordic_cell.sv
design/qte_sqrt_cell.sv
design/quaternion_to_euler_top.sv
bench/testbench.sv
